>>> src/lrmr_pkg.sv
// Shared types, constants and helper functions of the reservoir router.
`default_nettype none
package lrmr_pkg;

   localparam int CELL_COUNT_DEF = 4096;
   localparam int Q16_ONE        = 65536;
   localparam int Q16_THIRD      = 21845;
   localparam int FRONT_STAGES   = 5;
   localparam int RECIP_BITS     = 49;
   localparam int MIX_STAGES     = 3;
   localparam int PIPE_DEPTH     = FRONT_STAGES + RECIP_BITS + MIX_STAGES;
   localparam int WIDE_W         = 40;

   localparam logic signed [WIDE_W-1:0] SAT_MAX = WIDE_W'(32'sh7FFF_FFFF);
   localparam logic signed [WIDE_W-1:0] SAT_MIN = WIDE_W'(32'sh8000_0000);

   typedef struct packed {
      logic        [11:0] cell_index;
      logic        [16:0] route_coeff;
      logic signed [31:0] runoff_volume;
      logic signed [31:0] upstream_discharge;
      logic        [16:0] runoff_storm_share;
      logic        [16:0] runoff_surface_share;
      logic        [16:0] runoff_ground_share;
      logic signed [31:0] upstream_storm_flow;
      logic signed [31:0] upstream_surface_flow;
      logic signed [31:0] upstream_ground_flow;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_discharge;
      logic signed [31:0] inflow_total;
      logic        [30:0] storage_level;
      logic signed [31:0] storage_change;
      logic signed [31:0] storm_out_flow;
      logic signed [31:0] surface_out_flow;
      logic signed [31:0] ground_out_flow;
      logic        [16:0] storm_mix_share;
      logic        [16:0] surface_mix_share;
      logic        [16:0] ground_mix_share;
      logic signed [31:0] previous_out_discharge;
   } rsp_type;

   typedef struct packed {
      logic        [30:0] storage;
      logic        [16:0] storm_share;
      logic        [16:0] surface_share;
      logic        [16:0] ground_share;
      logic signed [31:0] last_outflow;
   } cell_state_type;

   typedef struct packed {
      logic        live;
      logic        wr;
      logic [11:0] cell_addr;
   } tag_type;

   typedef struct packed {
      logic signed [32:0] total;
      logic [2:0][33:0]   mix_b;
      logic [2:0][30:0]   run_a;
      logic signed [32:0] d_minus_h;
      logic signed [31:0] out_d;
      logic signed [31:0] inflow;
      logic        [30:0] stor;
      logic signed [31:0] chg;
      logic signed [31:0] prev;
   } route_ctx_type;

   function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] x);
      if (x > SAT_MAX) return 32'sh7FFF_FFFF;
      if (x < SAT_MIN) return 32'sh8000_0000;
      return x[31:0];
   endfunction

   function automatic logic [16:0] clamp_q16(input logic [16:0] v);
      return (v > 17'(Q16_ONE)) ? 17'(Q16_ONE) : v;
   endfunction

endpackage
`default_nettype wire

>>> src/linear_reservoir_mixing_router_unit.sv
// Top level of the linear reservoir router with flow-path mixing.
// An earlier word for the same cell that is still in flight holds issue of a new word
// until the earlier word is written back.
// Throughput: one word per cycle across distinct cells, set by the 49-stage reciprocal pipe.
// Reset: synchronous; after it the state memory is swept, with busy high until every cell is cleared.
// The result strobe lasts one cycle and cannot be stalled by the receiver.
`default_nettype none
module linear_reservoir_mixing_router_unit #(
   parameter int CELL_COUNT = lrmr_pkg::CELL_COUNT_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire lrmr_pkg::req_type req_word,
   output logic               busy,
   output logic               rsp_strobe,
   output lrmr_pkg::rsp_type  rsp_word
);
   import lrmr_pkg::*;

   localparam int IDX_W = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

   // Issue stage: one word waits here until no in-flight word writes its cell.
   logic    s0_live_ff, s0_live_in;
   req_type s0_req_ff;
   logic    s0_ok;
   logic    hazard;
   logic    issue;
   logic    accept;
   logic    clear_busy;

   // Tag line runs beside the datapath and marks which stage holds a live word.
   tag_type tag_ff [PIPE_DEPTH];
   tag_type tag_in0;
   tag_type tag_last;

   cell_state_type rd_state, wr_state;
   route_ctx_type  ctx_front, ctx_recip;
   logic [RECIP_BITS-1:0] recip;
   rsp_type rsp_next;
   rsp_type rsp_word_ff;
   logic    rsp_strobe_ff;

   assign s0_ok    = (32'(s0_req_ff.cell_index) < 32'(CELL_COUNT));
   assign tag_last = tag_ff[PIPE_DEPTH-1];

   // A word that writes back only at the end of the pipe must be seen by the
   // next word for that cell, so every live writing stage is compared.
   always_comb begin
      hazard = 1'b0;
      for (int j = 0; j < PIPE_DEPTH; j++) begin
         if (tag_ff[j].live && tag_ff[j].wr && tag_ff[j].cell_addr == s0_req_ff.cell_index)
            hazard = 1'b1;
      end
   end

   assign issue  = s0_live_ff && !hazard;
   assign busy   = clear_busy || (s0_live_ff && hazard);
   assign accept = start && !busy;

   always_comb begin
      s0_live_in = s0_live_ff;
      if (accept) begin
         s0_live_in = 1'b1;
      end else if (issue) begin
         s0_live_in = 1'b0;
      end
      tag_in0.live      = issue;
      tag_in0.wr        = issue && s0_ok;
      tag_in0.cell_addr = s0_req_ff.cell_index;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_live_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         for (int j = 0; j < PIPE_DEPTH; j++) tag_ff[j] <= '0;
      end else begin
         s0_live_ff    <= s0_live_in;
         rsp_strobe_ff <= tag_last.live;
         tag_ff[0]     <= tag_in0;
         for (int j = 1; j < PIPE_DEPTH; j++) tag_ff[j] <= tag_ff[j-1];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) s0_req_ff <= req_word;
      rsp_word_ff <= rsp_next;
   end

   // The memory read issues with the word; its data meets the word in the
   // first front stage. Out-of-range cells read as zero and never write.
   lrmr_state_mem #(
      .CELL_COUNT(CELL_COUNT)
   ) u_state_mem (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (issue),
      .rd_addr    (IDX_W'(s0_req_ff.cell_index)),
      .rd_data    (rd_state),
      .wr_en      (tag_last.live && tag_last.wr),
      .wr_addr    (IDX_W'(tag_last.cell_addr)),
      .wr_data    (wr_state),
      .clear_busy (clear_busy)
   );

   lrmr_front u_front (
      .clock      (clock),
      .item_in    (s0_req_ff),
      .cell_ok_in (s0_ok),
      .state_in   (rd_state),
      .ctx_out    (ctx_front)
   );

   lrmr_recip u_recip (
      .clock     (clock),
      .ctx_in    (ctx_front),
      .ctx_out   (ctx_recip),
      .recip_out (recip)
   );

   lrmr_mix u_mix (
      .clock     (clock),
      .ctx_in    (ctx_recip),
      .recip_in  (recip),
      .rsp_out   (rsp_next),
      .state_out (wr_state)
   );

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

endmodule
`default_nettype wire

>>> src/lrmr_state_mem.sv
// Per-cell state memory with a clearing sweep after reset.
`default_nettype none
module lrmr_state_mem #(
   parameter int CELL_COUNT = lrmr_pkg::CELL_COUNT_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         rd_en,
   input  wire logic [((CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1)-1:0] rd_addr,
   output lrmr_pkg::cell_state_type          rd_data,
   input  wire logic                         wr_en,
   input  wire logic [((CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1)-1:0] wr_addr,
   input  wire lrmr_pkg::cell_state_type     wr_data,
   output logic                              clear_busy
);
   import lrmr_pkg::*;

   localparam int IDX_W = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

   cell_state_type mem_ram [CELL_COUNT];
   cell_state_type rd_data_ff;
   logic             clear_busy_ff, clear_busy_in;
   logic [IDX_W-1:0] clear_cnt_ff, clear_cnt_in;
   logic             wsel_en;
   logic [IDX_W-1:0] wsel_addr;
   cell_state_type   wsel_data;

   always_comb begin
      clear_cnt_in  = clear_cnt_ff;
      clear_busy_in = clear_busy_ff;
      if (clear_busy_ff) begin
         clear_cnt_in = clear_cnt_ff + 1'b1;
         if (clear_cnt_ff == IDX_W'(CELL_COUNT - 1)) clear_busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clear_cnt_ff  <= '0;
      end else begin
         clear_busy_ff <= clear_busy_in;
         clear_cnt_ff  <= clear_cnt_in;
      end
   end

   always_comb begin
      wsel_en   = clear_busy_ff | wr_en;
      wsel_addr = clear_busy_ff ? clear_cnt_ff : wr_addr;
      wsel_data = clear_busy_ff ? '0 : wr_data;
   end

   always_ff @(posedge clock) begin
      if (wsel_en) mem_ram[wsel_addr] <= wsel_data;
      if (rd_en) rd_data_ff <= mem_ram[rd_addr];
   end

   assign rd_data    = rd_data_ff;
   assign clear_busy = clear_busy_ff;

endmodule
`default_nettype wire

>>> src/lrmr_front.sv
// Inflow, outflow, storage and mixing sums: five registered stages.
`default_nettype none
module lrmr_front (
   input  wire logic               clock,
   input  wire lrmr_pkg::req_type  item_in,
   input  wire logic               cell_ok_in,
   input  wire lrmr_pkg::cell_state_type state_in,
   output lrmr_pkg::route_ctx_type ctx_out
);
   import lrmr_pkg::*;

   // Stage 1: word register; the state word arrives from memory alongside.
   req_type item_ff;
   logic    ok_ff;

   logic        [30:0] s1;
   logic        [16:0] ps1 [3];
   logic        [16:0] pr1 [3];
   logic signed [31:0] u1 [3];
   logic signed [31:0] prev1;
   logic signed [30:0] h1;
   logic signed [32:0] qh1;
   logic signed [31:0] inflow1;
   logic signed [32:0] t1;

   always_comb begin
      s1     = ok_ff ? state_in.storage : '0;
      prev1  = ok_ff ? state_in.last_outflow : '0;
      ps1[0] = ok_ff ? state_in.storm_share : '0;
      ps1[1] = ok_ff ? state_in.surface_share : '0;
      ps1[2] = ok_ff ? state_in.ground_share : '0;
      pr1[0] = clamp_q16(item_ff.runoff_storm_share);
      pr1[1] = clamp_q16(item_ff.runoff_surface_share);
      pr1[2] = clamp_q16(item_ff.runoff_ground_share);
      u1[0]  = item_ff.upstream_storm_flow;
      u1[1]  = item_ff.upstream_surface_flow;
      u1[2]  = item_ff.upstream_ground_flow;
      h1      = 31'(item_ff.runoff_volume >>> 1);
      qh1     = 33'(item_ff.upstream_discharge) + 33'(h1);
      inflow1 = sat32(WIDE_W'(qh1));
      t1      = 33'(inflow1) + signed'(33'(s1));
   end

   // Stage 2 registers, then the products.
   logic        [16:0] c2_ff;
   logic        [16:0] pr2_ff [3];
   logic        [16:0] ps2_ff [3];
   logic signed [31:0] u2_ff [3];
   logic signed [30:0] h2_ff;
   logic signed [31:0] inflow2_ff, prev2_ff;
   logic signed [32:0] t2_ff;
   logic        [30:0] s2_ff;

   logic signed [50:0] ct2, nct2;
   logic signed [48:0] ha2 [3];
   logic        [47:0] sp2 [3];

   always_comb begin
      ct2  = signed'({1'b0, c2_ff}) * t2_ff;
      nct2 = signed'({1'b0, 17'(Q16_ONE) - c2_ff}) * t2_ff;
      for (int k = 0; k < 3; k++) begin
         ha2[k] = h2_ff * signed'({1'b0, pr2_ff[k]});
         sp2[k] = s2_ff * ps2_ff[k];
      end
   end

   // Stage 3 registers, then shifts, outflow fallback and storage clamp.
   logic signed [50:0] ct3_ff, nct3_ff;
   logic signed [48:0] ha3_ff [3];
   logic        [47:0] sp3_ff [3];
   logic signed [31:0] u3_ff [3];
   logic signed [30:0] h3_ff;
   logic signed [31:0] inflow3_ff, prev3_ff;
   logic signed [32:0] t3_ff;
   logic        [30:0] s3_ff;

   logic signed [30:0] a3 [3];
   logic        [30:0] sps3 [3];
   logic signed [34:0] o3, fb3, osel3, n3;
   logic signed [31:0] d3;
   logic        [30:0] stor3;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         a3[k]   = 31'(ha3_ff[k] >>> 16);
         sps3[k] = 31'(sp3_ff[k] >> 16);
      end
      o3    = 35'(ct3_ff >>> 16) + 35'(h3_ff);
      fb3   = 35'(inflow3_ff) + 35'(h3_ff);
      osel3 = (o3 < 35'sd0) ? fb3 : o3;
      d3    = sat32(WIDE_W'(osel3));
      n3    = 35'(nct3_ff >>> 16);
      if (n3 < 35'sd0) begin
         stor3 = '0;
      end else if (n3 > 35'(32'sh7FFF_FFFF)) begin
         stor3 = 31'h7FFF_FFFF;
      end else begin
         stor3 = n3[30:0];
      end
   end

   // Stage 4 registers, then the mixing sums and the storage change.
   logic signed [30:0] a4_ff [3];
   logic        [30:0] sps4_ff [3];
   logic signed [31:0] u4_ff [3];
   logic signed [30:0] h4_ff;
   logic signed [31:0] d4_ff, inflow4_ff, prev4_ff;
   logic        [30:0] stor4_ff, s4_ff;
   logic signed [32:0] t4_ff;

   route_ctx_type ctx4, ctx5_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         ctx4.mix_b[k] = 34'(a4_ff[k]) + 34'(u4_ff[k]) + signed'(34'(sps4_ff[k]));
         ctx4.run_a[k] = a4_ff[k];
      end
      ctx4.total     = t4_ff;
      ctx4.d_minus_h = 33'(d4_ff) - 33'(h4_ff);
      ctx4.out_d     = d4_ff;
      ctx4.inflow    = inflow4_ff;
      ctx4.stor      = stor4_ff;
      ctx4.chg       = signed'(32'(stor4_ff)) - signed'(32'(s4_ff));
      ctx4.prev      = prev4_ff;
   end

   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      ok_ff      <= cell_ok_in;

      c2_ff      <= clamp_q16(item_ff.route_coeff);
      h2_ff      <= h1;
      inflow2_ff <= inflow1;
      prev2_ff   <= prev1;
      t2_ff      <= t1;
      s2_ff      <= s1;

      ct3_ff     <= ct2;
      nct3_ff    <= nct2;
      h3_ff      <= h2_ff;
      inflow3_ff <= inflow2_ff;
      prev3_ff   <= prev2_ff;
      t3_ff      <= t2_ff;
      s3_ff      <= s2_ff;

      d4_ff      <= d3;
      h4_ff      <= h3_ff;
      inflow4_ff <= inflow3_ff;
      prev4_ff   <= prev3_ff;
      stor4_ff   <= stor3;
      s4_ff      <= s3_ff;
      t4_ff      <= t3_ff;

      for (int k = 0; k < 3; k++) begin
         pr2_ff[k]  <= pr1[k];
         ps2_ff[k]  <= ps1[k];
         u2_ff[k]   <= u1[k];
         ha3_ff[k]  <= ha2[k];
         sp3_ff[k]  <= sp2[k];
         u3_ff[k]   <= u2_ff[k];
         a4_ff[k]   <= a3[k];
         sps4_ff[k] <= sps3[k];
         u4_ff[k]   <= u3_ff[k];
      end

      ctx5_ff <= ctx4;
   end

   assign ctx_out = ctx5_ff;

endmodule
`default_nettype wire

>>> src/lrmr_recip.sv
// Pipelined restoring divider for the reciprocal 2^48 / total, one bit per stage.
`default_nettype none
module lrmr_recip (
   input  wire logic                      clock,
   input  wire lrmr_pkg::route_ctx_type   ctx_in,
   output lrmr_pkg::route_ctx_type        ctx_out,
   output logic [lrmr_pkg::RECIP_BITS-1:0] recip_out
);
   import lrmr_pkg::*;

   route_ctx_type         ctx_ff [RECIP_BITS];
   logic [31:0]           rem_ff [RECIP_BITS];
   logic [RECIP_BITS-1:0] quo_ff [RECIP_BITS];

   for (genvar j = 0; j < RECIP_BITS; j++) begin : g_stage
      logic [31:0]           rem_prev;
      logic [RECIP_BITS-1:0] quo_prev;
      route_ctx_type         ctx_prev;
      logic [32:0]           trial, dvs;
      logic                  take;

      if (j == 0) begin : g_first
         assign rem_prev = '0;
         assign quo_prev = '0;
         assign ctx_prev = ctx_in;
      end else begin : g_next
         assign rem_prev = rem_ff[j-1];
         assign quo_prev = quo_ff[j-1];
         assign ctx_prev = ctx_ff[j-1];
      end

      // The dividend is a single one in its top bit.
      assign trial = {rem_prev, (j == 0) ? 1'b1 : 1'b0};
      assign dvs   = {1'b0, ctx_prev.total[31:0]};
      assign take  = (trial >= dvs);

      always_ff @(posedge clock) begin
         rem_ff[j] <= take ? 32'(trial - dvs) : trial[31:0];
         quo_ff[j] <= {quo_prev[RECIP_BITS-2:0], take};
         ctx_ff[j] <= ctx_prev;
      end
   end

   assign ctx_out   = ctx_ff[RECIP_BITS-1];
   assign recip_out = quo_ff[RECIP_BITS-1];

endmodule
`default_nettype wire

>>> src/lrmr_mix.sv
// Share scaling by the reciprocal and the split of outflow into flow paths.
`default_nettype none
module lrmr_mix (
   input  wire logic                       clock,
   input  wire lrmr_pkg::route_ctx_type    ctx_in,
   input  wire logic [lrmr_pkg::RECIP_BITS-1:0] recip_in,
   output lrmr_pkg::rsp_type               rsp_out,
   output lrmr_pkg::cell_state_type        state_out
);
   import lrmr_pkg::*;

   // Stage 1: the 32 x 49 product split into two partial products.
   route_ctx_type ctx1_ff, ctx2_ff, ctx3_ff;
   logic [48:0]   ph1_ff [3];
   logic [63:0]   pl1_ff [3];

   // Stage 2: share select.
   logic [48:0] sum2 [3];
   logic [16:0] m2 [3];
   logic [16:0] m2_ff [3], m3_ff [3];

   // Stage 3: share times routed outflow.
   logic signed [50:0] po3 [3];
   logic signed [50:0] po3_ff [3];

   logic signed [31:0] flow [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sum2[k] = ph1_ff[k] + 49'(pl1_ff[k][63:32]);
         if (ctx1_ff.total <= 33'sd0) begin
            m2[k] = 17'(Q16_THIRD);
         end else if (signed'(ctx1_ff.mix_b[k]) <= 34'sd0) begin
            m2[k] = '0;
         end else if (signed'(ctx1_ff.mix_b[k]) >= 34'(ctx1_ff.total)) begin
            m2[k] = 17'(Q16_ONE);
         end else begin
            m2[k] = sum2[k][16:0];
         end
         po3[k]  = signed'({1'b0, m2_ff[k]}) * ctx2_ff.d_minus_h;
         flow[k] = sat32(WIDE_W'(po3_ff[k] >>> 16) + WIDE_W'(signed'(ctx3_ff.run_a[k])));
      end
   end

   always_ff @(posedge clock) begin
      ctx1_ff <= ctx_in;
      ctx2_ff <= ctx1_ff;
      ctx3_ff <= ctx2_ff;
      for (int k = 0; k < 3; k++) begin
         ph1_ff[k] <= ctx_in.mix_b[k][31:0] * recip_in[48:32];
         pl1_ff[k] <= ctx_in.mix_b[k][31:0] * recip_in[31:0];
         m2_ff[k]  <= m2[k];
         m3_ff[k]  <= m2_ff[k];
         po3_ff[k] <= po3[k];
      end
   end

   always_comb begin
      rsp_out.out_discharge          = ctx3_ff.out_d;
      rsp_out.inflow_total           = ctx3_ff.inflow;
      rsp_out.storage_level          = ctx3_ff.stor;
      rsp_out.storage_change         = ctx3_ff.chg;
      rsp_out.storm_out_flow         = flow[0];
      rsp_out.surface_out_flow       = flow[1];
      rsp_out.ground_out_flow        = flow[2];
      rsp_out.storm_mix_share        = m3_ff[0];
      rsp_out.surface_mix_share      = m3_ff[1];
      rsp_out.ground_mix_share       = m3_ff[2];
      rsp_out.previous_out_discharge = ctx3_ff.prev;

      state_out.storage       = ctx3_ff.stor;
      state_out.storm_share   = m3_ff[0];
      state_out.surface_share = m3_ff[1];
      state_out.ground_share  = m3_ff[2];
      state_out.last_outflow  = ctx3_ff.out_d;
   end

endmodule
`default_nettype wire

>>> src/lrmr_checker.sv
// Port-level checks of the reservoir router and their binding to the top level.
`default_nettype none
module lrmr_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         busy,
   input wire logic         rsp_strobe,
   input wire lrmr_pkg::rsp_type rsp_word
);
   import lrmr_pkg::*;

   // No result word may follow a reset cycle.
   a_no_strobe_after_reset: assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("result strobe right after reset");

   // The state sweep keeps the block busy after reset.
   a_busy_after_reset: assert property (@(posedge clock) reset |=> busy)
      else $error("busy low right after reset");

   // Mixed shares never exceed one.
   a_share_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_word.storm_mix_share <= 17'(Q16_ONE)) &&
                     (rsp_word.surface_mix_share <= 17'(Q16_ONE)) &&
                     (rsp_word.ground_mix_share <= 17'(Q16_ONE)))
      else $error("mixed share above one");

   // An emptied reservoir can only have lost water.
   a_empty_change: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.storage_level == 31'd0) |-> (rsp_word.storage_change <= 32'sd0))
      else $error("positive change into an empty reservoir");

endmodule

bind linear_reservoir_mixing_router_unit lrmr_checker u_lrmr_checker (
   .clock      (clock),
   .reset      (reset),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_word   (rsp_word)
);
`default_nettype wire
